@@ src/level_switch_pump_controller_defines.svh @@
// Assertion macros for the level switch pump controller checker.
`ifndef LEVEL_SWITCH_PUMP_CONTROLLER_DEFINES_SVH
`define LEVEL_SWITCH_PUMP_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LSPC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lspc assertion failed");

// Next-cycle implication, checked outside reset.
`define LSPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lspc assertion failed");

`endif

@@ src/lspc_pkg.sv @@
// Shared types and constants of the level switch pump controller.
package lspc_pkg;

    // Limit registers hold milliseconds; 255 minutes fit in 24 bits.
    localparam int LIMIT_BITS = 24;
    localparam int CFG_DATA_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int ELAPSED_W  = 16;

    localparam logic [LIMIT_BITS-1:0] MS_PER_MINUTE = LIMIT_BITS'(1000 * 60);

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RUN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_BREAK = 2'd1;

    // Reset values of the limits, in minutes
    localparam logic [CFG_DATA_W-1:0] MAX_RUN_RESET   = 8'd10;
    localparam logic [CFG_DATA_W-1:0] MIN_BREAK_RESET = 8'd60;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_REFILL = 2'd1,
        ST_HIGH   = 2'd2,
        ST_LOW    = 2'd3
    } t_status;

    // Relay state carried from item to item
    typedef struct packed {
        logic pump_on;
        logic skimmer_on;
    } t_relays;

    typedef struct packed {
        logic                 high_switch;
        logic                 mid_switch;
        logic                 low_switch;
        logic [ELAPSED_W-1:0] elapsed_ms;
    } t_item;

    typedef struct packed {
        logic    pump_drive;
        logic    skimmer_drive;
        t_status status;
    } t_result;

endpackage

@@ src/lspc_in_if.sv @@
// Input channel: switch levels and elapsed time.
interface lspc_in_if;
    logic                            valid;
    logic                            ready;
    logic                            high_switch;
    logic                            mid_switch;
    logic                            low_switch;
    logic [lspc_pkg::ELAPSED_W-1:0]  elapsed_ms;

    modport source (output valid, high_switch, mid_switch, low_switch, elapsed_ms,
                    input ready);
    modport sink   (input valid, high_switch, mid_switch, low_switch, elapsed_ms,
                    output ready);
endinterface

@@ src/lspc_out_if.sv @@
// Output channel: relay commands and status.
interface lspc_out_if;
    logic       valid;
    logic       ready;
    logic       pump_drive;
    logic       skimmer_drive;
    logic [1:0] status;

    modport source (output valid, pump_drive, skimmer_drive, status, input ready);
    modport sink   (input valid, pump_drive, skimmer_drive, status, output ready);
endinterface

@@ src/level_switch_pump_controller.sv @@
// Top level of the level switch pump controller.
// Takes one transaction per clock cycle while the output is not stalled; its
// result moves from the input register into the result register and stays
// until taken.
// The relay state and both timers update combinationally from the input
// register, so consecutive transactions never wait on each other. A stalled
// output holds the result register and the input register; the input side
// keeps accepting while the input register is free. Configuration writes
// take effect on the next cycle; limits are held in milliseconds.
module level_switch_pump_controller #(
    parameter int TIMER_BITS = 24
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    lspc_in_if.sink                          i_in,
    lspc_out_if.source                       o_out,
    input  logic                             i_cfg_we,
    input  logic [lspc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lspc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic                            r_in_vld;
    lspc_pkg::t_item                 r_item;
    logic                            r_out_vld;
    lspc_pkg::t_result               r_result;
    lspc_pkg::t_relays               r_relays;
    logic [TIMER_BITS-1:0]           r_since_on;
    logic [TIMER_BITS-1:0]           r_since_off;

    lspc_pkg::t_relays               n_relays;
    logic [TIMER_BITS-1:0]           n_since_on;
    logic [TIMER_BITS-1:0]           n_since_off;
    lspc_pkg::t_result               n_result;

    logic [lspc_pkg::LIMIT_BITS-1:0] max_run_ms;
    logic [lspc_pkg::LIMIT_BITS-1:0] min_break_ms;
    logic                            advance;
    logic                            in_take;

    lspc_limits u_limits (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_max_run_ms   (max_run_ms),
        .o_min_break_ms (min_break_ms)
    );

    lspc_step #(
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .i_item         (r_item),
        .i_relays       (r_relays),
        .i_since_on     (r_since_on),
        .i_since_off    (r_since_off),
        .i_max_run_ms   (max_run_ms),
        .i_min_break_ms (min_break_ms),
        .o_relays       (n_relays),
        .o_since_on     (n_since_on),
        .o_since_off    (n_since_off),
        .o_result       (n_result)
    );

    // Advance the held item when the result register is free or being taken
    assign advance     = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready  = !r_in_vld || advance;
    assign in_take     = i_in.valid && i_in.ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item.high_switch <= i_in.high_switch;
            r_item.mid_switch  <= i_in.mid_switch;
            r_item.low_switch  <= i_in.low_switch;
            r_item.elapsed_ms  <= i_in.elapsed_ms;
        end
    end

    // State and result register: update on each advanced item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld   <= 1'b0;
            r_relays    <= '0;
            r_since_on  <= '0;
            r_since_off <= '0;
        end else if (advance) begin
            r_out_vld   <= 1'b1;
            r_relays    <= n_relays;
            r_since_on  <= n_since_on;
            r_since_off <= n_since_off;
        end else if (o_out.ready) begin
            r_out_vld   <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.pump_drive    = r_result.pump_drive;
    assign o_out.skimmer_drive = r_result.skimmer_drive;
    assign o_out.status        = r_result.status;

endmodule

@@ src/lspc_limits.sv @@
// Limit registers: minutes written on the config port, held in milliseconds.
module lspc_limits (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [lspc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [lspc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic [lspc_pkg::LIMIT_BITS-1:0]      o_max_run_ms,
    output logic [lspc_pkg::LIMIT_BITS-1:0]      o_min_break_ms
);

    logic [lspc_pkg::LIMIT_BITS-1:0] r_max_run_ms;
    logic [lspc_pkg::LIMIT_BITS-1:0] r_min_break_ms;
    logic [lspc_pkg::LIMIT_BITS-1:0] cfg_ms;

    // Scale the written minutes to milliseconds
    assign cfg_ms = lspc_pkg::LIMIT_BITS'(i_cfg_data) * lspc_pkg::MS_PER_MINUTE;

    // Hold limits; ignore indexes outside the register list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_run_ms   <= lspc_pkg::LIMIT_BITS'(lspc_pkg::MAX_RUN_RESET)
                              * lspc_pkg::MS_PER_MINUTE;
            r_min_break_ms <= lspc_pkg::LIMIT_BITS'(lspc_pkg::MIN_BREAK_RESET)
                              * lspc_pkg::MS_PER_MINUTE;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == lspc_pkg::CFG_MAX_RUN) begin
                r_max_run_ms <= cfg_ms;
            end
            if (i_cfg_idx == lspc_pkg::CFG_MIN_BREAK) begin
                r_min_break_ms <= cfg_ms;
            end
        end
    end

    assign o_max_run_ms   = r_max_run_ms;
    assign o_min_break_ms = r_min_break_ms;

endmodule

@@ src/lspc_step.sv @@
// Per-item decision: timer update, level priority and relay commands.
module lspc_step #(
    parameter int TIMER_BITS = 24
) (
    input  lspc_pkg::t_item                      i_item,
    input  lspc_pkg::t_relays                    i_relays,
    input  logic [TIMER_BITS-1:0]                i_since_on,
    input  logic [TIMER_BITS-1:0]                i_since_off,
    input  logic [lspc_pkg::LIMIT_BITS-1:0]      i_max_run_ms,
    input  logic [lspc_pkg::LIMIT_BITS-1:0]      i_min_break_ms,
    output lspc_pkg::t_relays                    o_relays,
    output logic [TIMER_BITS-1:0]                o_since_on,
    output logic [TIMER_BITS-1:0]                o_since_off,
    output lspc_pkg::t_result                    o_result
);

    localparam int CMP_W = (TIMER_BITS > lspc_pkg::LIMIT_BITS) ?
                           TIMER_BITS : lspc_pkg::LIMIT_BITS;

    logic [TIMER_BITS:0]   on_sum;
    logic [TIMER_BITS:0]   off_sum;
    logic [TIMER_BITS-1:0] on_sat;
    logic [TIMER_BITS-1:0] off_sat;
    logic                  run_over;
    logic                  break_over;

    // Saturating add of the elapsed time to both timers
    assign on_sum  = {1'b0, i_since_on}  + (TIMER_BITS+1)'(i_item.elapsed_ms);
    assign off_sum = {1'b0, i_since_off} + (TIMER_BITS+1)'(i_item.elapsed_ms);
    assign on_sat  = on_sum[TIMER_BITS]  ? '1 : on_sum[TIMER_BITS-1:0];
    assign off_sat = off_sum[TIMER_BITS] ? '1 : off_sum[TIMER_BITS-1:0];

    // Compare the updated timers with the limits
    assign run_over   = CMP_W'(on_sat)  > CMP_W'(i_max_run_ms);
    assign break_over = CMP_W'(off_sat) > CMP_W'(i_min_break_ms);

    // Pick the action in priority order: high alarm, low alarm, refill, level ok
    always_comb begin
        o_relays    = i_relays;
        o_since_on  = on_sat;
        o_since_off = off_sat;
        if (i_item.high_switch || !i_item.low_switch) begin
            o_relays.pump_on    = 1'b0;
            o_relays.skimmer_on = 1'b0;
            o_since_off         = '0;
            o_result.status     = i_item.high_switch ? lspc_pkg::ST_HIGH : lspc_pkg::ST_LOW;
        end else if (!i_item.mid_switch) begin
            if (i_relays.pump_on) begin
                if (run_over) begin
                    o_relays.pump_on = 1'b0;
                    o_since_off      = '0;
                end
            end else if (break_over) begin
                o_relays.pump_on = 1'b1;
                o_since_on       = '0;
            end
            o_result.status = lspc_pkg::ST_REFILL;
        end else begin
            if (i_relays.pump_on) begin
                o_relays.pump_on = 1'b0;
                o_since_off      = '0;
            end
            o_relays.skimmer_on = 1'b1;
            o_result.status     = lspc_pkg::ST_OK;
        end
        o_result.pump_drive    = o_relays.pump_on;
        o_result.skimmer_drive = o_relays.skimmer_on;
    end

endmodule

@@ src/lspc_checker.sv @@
// Port-level checker for the level switch pump controller, bound to the top.
`include "level_switch_pump_controller_defines.svh"

module lspc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_pump_drive,
    input logic       i_skimmer_drive,
    input logic [1:0] i_status
);

    // A stalled result holds its payload
    `LSPC_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_pump_drive) && $stable(i_skimmer_drive) && $stable(i_status))

    // Alarms switch both relays off
    `LSPC_ASSERT_SAME(a_alarm_off, i_clk, i_rst_n, i_out_valid && (i_status == lspc_pkg::ST_HIGH || i_status == lspc_pkg::ST_LOW), !i_pump_drive && !i_skimmer_drive)

    // Correct level runs the skimmer and stops the pump
    `LSPC_ASSERT_SAME(a_level_ok, i_clk, i_rst_n, i_out_valid && i_status == lspc_pkg::ST_OK, !i_pump_drive && i_skimmer_drive)

    // The pump runs only while refilling
    `LSPC_ASSERT_SAME(a_pump_refill, i_clk, i_rst_n, i_out_valid && i_pump_drive, i_status == lspc_pkg::ST_REFILL)

endmodule

bind level_switch_pump_controller lspc_checker u_lspc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_pump_drive    (o_out.pump_drive),
    .i_skimmer_drive (o_out.skimmer_drive),
    .i_status        (o_out.status)
);
